/* rtl/core/sem_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 Sobel edge magnitude block.
// Used by the line memory, the square root unit, the top level and the checker.
package sem_pkg;

    // Pixel and arithmetic widths.
    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int CFG_WIDTH_W = 12;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SQ_W        = 16;
    localparam int ROOT_W      = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Item kinds.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Register values after reset.
    localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

    // Saturated magnitude and the first trial bit of the square root.
    localparam logic [PIX_W-1:0] PIX_MAX        = 8'hFF;
    localparam logic [SQ_W-1:0]  SQRT_FIRST_BIT = 16'h4000;

    typedef logic [PIX_W-1:0] t_pixel;

    // One line memory entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_word;

endpackage

/* rtl/core/sem_line_mem.sv */
`timescale 1ns / 1ps
// Line memory holding the two previous rows, one entry per column.
// Depends on sem_pkg for the entry type.
module sem_line_mem
    import sem_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line_word    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line_word    i_wr_data
);

    t_line_word r_mem [DEPTH];
    t_line_word r_rd_data;

    // Synchronous write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Synchronous read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sem_isqrt.sv */
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
// Depends on sem_pkg for the operand widths.
module sem_isqrt
    import sem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic            r_busy;
    logic [SQ_W-1:0] r_val;
    logic [SQ_W-1:0] r_root;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W:0]   trial;
    logic            ge;
    logic [SQ_W-1:0] n_val;
    logic [SQ_W-1:0] n_root;

    // One step of the digit-by-digit root: try root plus the current bit.
    always_comb begin
        trial = {1'b0, r_root} + {1'b0, r_bit};
        ge    = {1'b0, r_val} >= trial;
        if (ge) begin
            n_val  = r_val - trial[SQ_W-1:0];
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_val  = r_val;
            n_root = r_root >> 1;
        end
    end

    // The bit walks down two places per step; eight steps cover a 16-bit value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_val  <= i_value;
            r_root <= '0;
            r_bit  <= SQRT_FIRST_BIT;
        end else if (r_busy) begin
            if (r_bit != '0) begin
                r_val  <= n_val;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_bit == '0);
    assign o_root = r_root[ROOT_W-1:0];

endmodule

/* rtl/core/sobel_edge_magnitude_3x3.sv */
// Streaming 3x3 Sobel edge magnitude. Pixels enter in raster order and results leave in
// the same order, one row plus one pixel behind; flush items drain what is pending once
// the frame is in. A pixel or flush item with no result goes through the column state
// only; a flush item that arrives before the frame is complete is taken and ignored. A
// border result goes through the column, gradient and output states, a saturated result
// also through the sum state and an interior result also through the square root state
// with its eight-step unit; a result also waits while the output register is still held
// by a stall. The block works on one item at a time: the line memory is read as the item
// is accepted, and the column is written back in the next cycle, before the next read.
// Depends on sem_pkg, sem_line_mem and sem_isqrt.
`timescale 1ns / 1ps
module sobel_edge_magnitude_3x3
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [PIX_W-1:0]      i_pixel_value,
    // Result item channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_result_pixel,
    output logic                  o_frame_last,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
    localparam int IRW  = ROW_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_GRAD,
        S_SUM,
        S_SQRT,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [CFG_WIDTH_W-1:0] r_image_width;
    logic [ROW_W-1:0]       r_image_height;
    logic [CW-1:0]          r_in_col;
    logic [IRW-1:0]         r_in_row;
    logic [CW-1:0]          r_out_col;
    logic [ROW_W-1:0]       r_out_row;
    t_pixel                 r_win [9];
    t_pixel                 r_pix;
    logic                   r_all_in;
    logic [19:0]            r_sq_x;
    logic [19:0]            r_sq_y;
    t_pixel                 r_res;
    logic                   r_o_valid;
    t_pixel                 r_o_result;
    logic                   r_o_last;

    logic [CMPW-1:0]  w_ext;
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             all_in;
    logic             proceed;
    logic             out_done;
    logic             in_take;
    logic             rd_en;
    logic             wr_en;
    t_line_word       rd_data;
    t_line_word       wr_data;
    t_pixel           col_vals [3];
    logic             emit;
    logic             in_col_wrap;
    logic [CW-1:0]    n_in_col;
    logic [IRW-1:0]   n_in_row;
    logic             out_col_end;
    logic             out_row_end;
    logic             border;
    logic             last;
    logic [CW-1:0]    n_out_col;
    logic [ROW_W-1:0] n_out_row;
    logic [9:0]       s_xp;
    logic [9:0]       s_xn;
    logic [9:0]       s_yp;
    logic [9:0]       s_yn;
    logic [9:0]       abs_x;
    logic [9:0]       abs_y;
    logic [20:0]      sq_sum;
    logic             sat;
    logic             sqrt_start;
    logic             sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic             out_load;
    logic             do_restart;

    // Effective frame size: zero acts as one, the width is clamped to the line memory.
    assign w_ext = CMPW'(r_image_width);
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = WW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(w_ext);
        end
    end
    assign eff_h = (r_image_height == '0) ? ROW_W'(1) : r_image_height;

    // Item acceptance. A flush item before the frame is complete changes nothing.
    assign all_in   = r_in_row >= IRW'(eff_h);
    assign proceed  = !(i_mode == MODE_FLUSH && !all_in);
    assign out_done = r_out_row >= eff_h;
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && (r_state == S_IDLE);

    // Line memory: read at acceptance, write the shifted column in the next cycle.
    assign rd_en = in_take && proceed && !out_done;
    assign wr_en = (r_state == S_COL) && !r_all_in;
    assign wr_data.upper  = col_vals[1];
    assign wr_data.middle = r_pix;

    sem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_in_col),
        .i_wr_data (wr_data)
    );

    // New window column; rows not yet seen in this frame read as zero.
    assign col_vals[0] = (r_in_row >= IRW'(2)) ? rd_data.upper : '0;
    assign col_vals[1] = (r_in_row >= IRW'(1)) ? rd_data.middle : '0;
    assign col_vals[2] = r_all_in ? '0 : r_pix;

    // Input position and whether this item completes a result.
    assign emit = (r_in_row >= IRW'(2)) || ((r_in_row == IRW'(1)) && (r_in_col != '0));
    assign in_col_wrap = (WW'(r_in_col) + WW'(1)) >= eff_w;
    assign n_in_col    = in_col_wrap ? '0 : r_in_col + CW'(1);
    assign n_in_row    = in_col_wrap ? r_in_row + IRW'(1) : r_in_row;

    // Output position, border test and end of frame.
    assign out_col_end = (WW'(r_out_col) + WW'(1)) >= eff_w;
    assign out_row_end = (IRW'(r_out_row) + IRW'(1)) >= IRW'(eff_h);
    assign border      = (r_out_row == '0) || out_row_end || (r_out_col == '0) || out_col_end;
    assign last        = out_row_end && out_col_end;
    assign n_out_col   = out_col_end ? '0 : r_out_col + CW'(1);
    assign n_out_row   = out_col_end ? r_out_row + ROW_W'(1) : r_out_row;

    // Gradient magnitudes as absolute differences of the weighted column and row sums.
    always_comb begin
        s_xp = 10'(r_win[2]) + 10'({r_win[5], 1'b0}) + 10'(r_win[8]);
        s_xn = 10'(r_win[0]) + 10'({r_win[3], 1'b0}) + 10'(r_win[6]);
        s_yp = 10'(r_win[6]) + 10'({r_win[7], 1'b0}) + 10'(r_win[8]);
        s_yn = 10'(r_win[0]) + 10'({r_win[1], 1'b0}) + 10'(r_win[2]);
        abs_x = (s_xp >= s_xn) ? s_xp - s_xn : s_xn - s_xp;
        abs_y = (s_yp >= s_yn) ? s_yp - s_yn : s_yn - s_yp;
    end

    // Sum of squares; anything at or above 256 squared saturates.
    assign sq_sum     = 21'(r_sq_x) + 21'(r_sq_y);
    assign sat        = |sq_sum[20:SQ_W];
    assign sqrt_start = (r_state == S_SUM) && !sat;

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sq_sum[SQ_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // A finished result moves to the output register once that is free.
    assign out_load   = (r_state == S_OUT) && (!r_o_valid || !i_stall);
    assign do_restart = i_cfg_we
                     || (in_take && proceed && out_done)
                     || (out_load && last);

    // Sequencer, counters, window and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_o_valid      <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            // The output register fills on a load and empties when its item is taken.
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (rd_en) begin
                        r_pix    <= i_pixel_value;
                        r_all_in <= all_in;
                        r_state  <= S_COL;
                    end
                end
                S_COL: begin
                    if (!do_restart) begin
                        for (int r = 0; r < 3; r++) begin
                            r_win[r*3]   <= r_win[r*3+1];
                            r_win[r*3+1] <= r_win[r*3+2];
                            r_win[r*3+2] <= col_vals[r];
                        end
                        r_in_col <= n_in_col;
                        r_in_row <= n_in_row;
                    end
                    r_state  <= emit ? S_GRAD : S_IDLE;
                end
                S_GRAD: begin
                    if (border) begin
                        r_res   <= r_win[4];
                        r_state <= S_OUT;
                    end else begin
                        r_sq_x  <= 20'(abs_x) * 20'(abs_x);
                        r_sq_y  <= 20'(abs_y) * 20'(abs_y);
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sat) begin
                        r_res   <= PIX_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_res   <= sqrt_root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_result <= r_res;
                        r_o_last   <= last;
                        if (!do_restart) begin
                            r_out_col <= n_out_col;
                            r_out_row <= n_out_row;
                        end
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // The user must issue configuration writes only while idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_image_width <= i_cfg_data[CFG_WIDTH_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_image_height <= i_cfg_data[ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Frame restart clears the positions and the window.
            if (do_restart) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                for (int k = 0; k < 9; k++) begin
                    r_win[k] <= '0;
                end
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_pixel = r_o_result;
    assign o_frame_last   = r_o_last;

endmodule

/* rtl/core/sem_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
// Depends on sem_pkg for the item kind codes.
module sem_checker
    import sem_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_mode,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIX_W-1:0] o_result_pixel,
    input logic             o_frame_last,
    input logic             i_cfg_we
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_pixel) && $stable(o_frame_last))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // A pixel item always keeps the block busy for the following cycle.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == MODE_PIXEL) && !i_cfg_we |=> o_stall)
        else $error("pixel item accepted without work cycle");

    // A new result only appears after the block was busy with an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while idle");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_mode         (i_mode),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_pixel (o_result_pixel),
    .o_frame_last   (o_frame_last),
    .i_cfg_we       (i_cfg_we)
);
